FILE: rtl/core/pfdrc_pkg.sv
// Shared types and constants for the packet buffer with duplicate check and range count.
`default_nettype none

package pfdrc_pkg;

  // Operation codes carried on the input channel.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_FORWARD = 2'd1;
  localparam logic [1:0] OP_COUNT   = 2'd2;

  // Width of the limit register, of the held count and of the match count.
  localparam int unsigned LIM_W = 9;

  // Limit value after reset.
  localparam logic [LIM_W-1:0] LIMIT_RESET = 9'd256;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic clear;       // start of a new scan: drop the old result
    logic valid;       // read data from the store is a live entry
    logic count_mode;  // destination plus time range test instead of full match
  } match_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/pfdrc_store.sv
// Entry store: one write port and one registered read port over DEPTH slots.
`default_nettype none

module pfdrc_store #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned NODE_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [NODE_BITS-1:0]         wr_source,
  input  wire logic [NODE_BITS-1:0]         wr_destination,
  input  wire logic [TIME_BITS-1:0]         wr_time,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [NODE_BITS-1:0]         rd_source,
  output logic      [NODE_BITS-1:0]         rd_destination,
  output logic      [TIME_BITS-1:0]         rd_time
);

  localparam int unsigned ENTRY_W = 2 * NODE_BITS + TIME_BITS;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_source, wr_destination, wr_time};
    end
  end

  // The read register only moves on a read, so it keeps the last entry fetched.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_source      = rd_data_r[ENTRY_W-1 -: NODE_BITS];
  assign rd_destination = rd_data_r[TIME_BITS +: NODE_BITS];
  assign rd_time        = rd_data_r[TIME_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/pfdrc_match.sv
// Shared compare unit: tests one stored entry per cycle and accumulates hit and count.
`default_nettype none

module pfdrc_match #(
  parameter int unsigned NODE_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pfdrc_pkg::match_ctl_t         ctl,
  input  wire logic [NODE_BITS-1:0]          key_source,
  input  wire logic [NODE_BITS-1:0]          key_destination,
  input  wire logic [TIME_BITS-1:0]          key_time,
  input  wire logic [TIME_BITS-1:0]          key_start,
  input  wire logic [TIME_BITS-1:0]          key_end,
  input  wire logic [NODE_BITS-1:0]          ent_source,
  input  wire logic [NODE_BITS-1:0]          ent_destination,
  input  wire logic [TIME_BITS-1:0]          ent_time,
  output logic                               hit,
  output logic [pfdrc_pkg::LIM_W-1:0]        count
);

  logic                          hit_r;
  logic                          hit_nxt;
  logic [pfdrc_pkg::LIM_W-1:0]   count_r;
  logic [pfdrc_pkg::LIM_W-1:0]   count_nxt;
  logic                          dst_eq;
  logic                          full_eq;
  logic                          in_range;
  logic                          match;

  assign dst_eq   = (ent_destination == key_destination);
  assign full_eq  = dst_eq && (ent_source == key_source) && (ent_time == key_time);
  // A reversed range can never be satisfied, so it counts nothing by itself.
  assign in_range = dst_eq && (ent_time >= key_start) && (ent_time <= key_end);
  assign match    = ctl.valid && (ctl.count_mode ? in_range : full_eq);

  always_comb begin
    hit_nxt   = hit_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      hit_nxt   = 1'b0;
      count_nxt = '0;
    end else if (match) begin
      hit_nxt   = 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      count_r <= '0;
    end else begin
      hit_r   <= hit_nxt;
      count_r <= count_nxt;
    end
  end

  assign hit   = hit_r;
  assign count = count_r;

endmodule

`default_nettype wire

FILE: rtl/core/packet_fifo_dedup_range_count.sv
// Top level: packet buffer with duplicate check, forward and range count under a sequencer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    opcode, source, destination, timestamp, times
//   out      output     out_valid/out_ready  ok, packet fields, match count
//   cfg      input      cfg_wr_en            memory limit
//
// An add or a count walks the held entries through one compare unit, one per cycle off
// the store's read port (an add walks none when the limit is zero); the result then loads
// from the finish step, and the next transaction is taken once the sequencer is idle.
// A forward reads only the oldest slot, and none when empty; other opcodes read nothing.
// Reset clears the head pointer and held count; the store itself is not cleared.
// A result waits in the output register while the next transaction is scanned; the
// next result waits in the finish step until the previous one is read.
`default_nettype none

module packet_fifo_dedup_range_count #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned NODE_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [NODE_BITS-1:0]          in_source,
  input  wire logic [NODE_BITS-1:0]          in_destination,
  input  wire logic [TIME_BITS-1:0]          in_timestamp,
  input  wire logic [TIME_BITS-1:0]          in_start_time,
  input  wire logic [TIME_BITS-1:0]          in_end_time,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_ok,
  output logic      [NODE_BITS-1:0]          out_source,
  output logic      [NODE_BITS-1:0]          out_destination,
  output logic      [TIME_BITS-1:0]          out_timestamp,
  output logic      [pfdrc_pkg::LIM_W-1:0]   out_match_count,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pfdrc_pkg::LIM_W-1:0]   cfg_wr_data
);

  localparam int unsigned LIM_W  = pfdrc_pkg::LIM_W;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SUM_W  = ((ADDR_W > LIM_W) ? ADDR_W : LIM_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(DEPTH);
  localparam logic [31:0]       DEPTH_L   = 32'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LIM_W-1:0]       limit_r;
  logic [ADDR_W-1:0]      head_r, head_nxt;
  logic [LIM_W-1:0]       held_r, held_nxt;
  logic [LIM_W-1:0]       idx_r, idx_nxt;
  logic [LIM_W-1:0]       len_r, len_nxt;
  logic [ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic                   pend_r, pend_nxt;

  // Captured transaction.
  logic [1:0]             op_r;
  logic [NODE_BITS-1:0]   src_r;
  logic [NODE_BITS-1:0]   dst_r;
  logic [TIME_BITS-1:0]   tim_r;
  logic [TIME_BITS-1:0]   t0_r;
  logic [TIME_BITS-1:0]   t1_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_ok_r, out_ok_nxt;
  logic [NODE_BITS-1:0]   out_src_r, out_src_nxt;
  logic [NODE_BITS-1:0]   out_dst_r, out_dst_nxt;
  logic [TIME_BITS-1:0]   out_tim_r, out_tim_nxt;
  logic [LIM_W-1:0]       out_cnt_r, out_cnt_nxt;

  logic [LIM_W-1:0]       lim;
  logic                   accept;
  logic                   rd_en;
  logic                   load_out;
  logic                   st_wr_en;
  logic [SUM_W-1:0]       tail_sum;
  logic [ADDR_W-1:0]      tail_slot;
  logic [ADDR_W-1:0]      head_inc;
  logic [NODE_BITS-1:0]   rd_source;
  logic [NODE_BITS-1:0]   rd_destination;
  logic [TIME_BITS-1:0]   rd_time;
  logic                   scan_hit;
  logic [LIM_W-1:0]       scan_count;
  pfdrc_pkg::match_ctl_t  mctl;

  assign lim      = (32'(limit_r) < DEPTH_L) ? limit_r : LIM_W'(DEPTH);
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign rd_en    = (state_r == ST_SCAN) && (idx_r != len_r);
  assign load_out = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // The new entry always lands at head + held, whether or not the oldest is dropped.
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(held_r);
  assign tail_slot = (tail_sum >= DEPTH_S) ? ADDR_W'(tail_sum - DEPTH_S)
                                           : ADDR_W'(tail_sum);
  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign st_wr_en  = load_out && (op_r == pfdrc_pkg::OP_ADD) && (lim != '0) && !scan_hit;

  assign mctl.clear      = accept;
  assign mctl.valid      = pend_r;
  assign mctl.count_mode = (op_r == pfdrc_pkg::OP_COUNT);

  pfdrc_store #(
    .DEPTH     (DEPTH),
    .NODE_BITS (NODE_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk            (clk),
    .wr_en          (st_wr_en),
    .wr_addr        (tail_slot),
    .wr_source      (src_r),
    .wr_destination (dst_r),
    .wr_time        (tim_r),
    .rd_en          (rd_en),
    .rd_addr        (ptr_r),
    .rd_source      (rd_source),
    .rd_destination (rd_destination),
    .rd_time        (rd_time)
  );

  pfdrc_match #(
    .NODE_BITS (NODE_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_match (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (mctl),
    .key_source      (src_r),
    .key_destination (dst_r),
    .key_time        (tim_r),
    .key_start       (t0_r),
    .key_end         (t1_r),
    .ent_source      (rd_source),
    .ent_destination (rd_destination),
    .ent_time        (rd_time),
    .hit             (scan_hit),
    .count           (scan_count)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    held_nxt      = held_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          ptr_nxt   = head_r;
          state_nxt = ST_SCAN;
          case (in_opcode)
            pfdrc_pkg::OP_ADD:     len_nxt = (lim == '0) ? '0 : held_r;
            pfdrc_pkg::OP_FORWARD: len_nxt = (held_r != '0) ? LIM_W'(1) : '0;
            pfdrc_pkg::OP_COUNT:   len_nxt = held_r;
            default:               len_nxt = '0;
          endcase
        end
      end
      ST_SCAN: begin
        // One read issued per cycle; the compare sees its data in the following cycle.
        pend_nxt = rd_en;
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
          ptr_nxt = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (st_wr_en) begin
            if (held_r >= lim) begin
              head_nxt = head_inc;
            end else begin
              held_nxt = held_r + 1'b1;
            end
          end else if ((op_r == pfdrc_pkg::OP_FORWARD) && (held_r != '0)) begin
            head_nxt = head_inc;
            held_nxt = held_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= pfdrc_pkg::LIMIT_RESET;
      head_r      <= '0;
      held_r      <= '0;
      idx_r       <= '0;
      len_r       <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      src_r <= in_source;
      dst_r <= in_destination;
      tim_r <= in_timestamp;
      t0_r  <= in_start_time;
      t1_r  <= in_end_time;
    end
  end

  always_comb begin
    out_ok_nxt  = 1'b0;
    out_src_nxt = '0;
    out_dst_nxt = '0;
    out_tim_nxt = '0;
    out_cnt_nxt = '0;
    case (op_r)
      pfdrc_pkg::OP_ADD: begin
        out_ok_nxt = (lim != '0) && !scan_hit;
      end
      pfdrc_pkg::OP_FORWARD: begin
        // The read register still holds the oldest entry fetched during the scan.
        if (held_r != '0) begin
          out_ok_nxt  = 1'b1;
          out_src_nxt = rd_source;
          out_dst_nxt = rd_destination;
          out_tim_nxt = rd_time;
        end
      end
      pfdrc_pkg::OP_COUNT: begin
        out_cnt_nxt = scan_count;
      end
      default: begin
        out_ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok_r  <= out_ok_nxt;
      out_src_r <= out_src_nxt;
      out_dst_r <= out_dst_nxt;
      out_tim_r <= out_tim_nxt;
      out_cnt_r <= out_cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_source      = out_src_r;
  assign out_destination = out_dst_r;
  assign out_timestamp   = out_tim_r;
  assign out_match_count = out_cnt_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_r) <= DEPTH_L)
    else $error("held count exceeds the store depth");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the finish step");

  a_write_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr_en |-> (state_r == ST_FINISH) && !scan_hit)
    else $error("store written outside the finish step or for a duplicate");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= len_r))
    else $error("scan index ran past the scan length");

endmodule

`default_nettype wire
